### rtl/msrp_pkg.sv
// Package for the Modbus sensor reply parser: word types, status codes,
// frame constants and CRC-16/MODBUS constants. No dependencies.
package msrp_pkg;

  localparam int MAX_FRAME_BYTES = 128;
  localparam int HDR_LEN         = 7;

  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;
  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  READ_BYTE_COUNT   = 8'h04;
  localparam logic [7:0]  SLAVE_ADDR_RESET  = 8'h01;

  typedef enum logic [1:0] {
    FS_VALID      = 2'd0,
    FS_BAD_FUNC   = 2'd1,
    FS_OTHER_ADDR = 2'd2,
    FS_SHORT      = 2'd3
  } frame_status_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       last_byte;
  } rx_word_t;

  typedef struct packed {
    logic [15:0]   temperature_raw;
    logic [15:0]   humidity_raw;
    frame_status_t frame_status;
    logic          crc_ok;
  } res_word_t;

  // View of the frame with the current byte folded in.
  typedef struct packed {
    logic [HDR_LEN-1:0][7:0] hdr;
    logic                    short_frame;
    logic [15:0]             crc;
  } frame_snap_t;

endpackage

### rtl/msrp_frame_acc.sv
// Frame accumulator: running CRC, byte position and the first header bytes.
// Depends on msrp_pkg.
module msrp_frame_acc #(
  parameter int MaxFrameBytes = msrp_pkg::MAX_FRAME_BYTES
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   accept,
  input  msrp_pkg::rx_word_t     rx_word,
  output msrp_pkg::frame_snap_t  snap
);
  import msrp_pkg::*;

  localparam int PosW = $clog2(MaxFrameBytes + 1);

  logic [PosW-1:0]         pos;
  logic [PosW-1:0]         pos_next;
  logic [15:0]             crc;
  logic [15:0]             crc_next;
  logic [HDR_LEN-1:0][7:0] hdr;
  logic [HDR_LEN-1:0][7:0] hdr_next;

  // Bit-serial CRC-16/MODBUS over one byte, LSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in,
                                           input logic [7:0]  b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  always_comb begin
    hdr_next = hdr;
    for (int i = 0; i < HDR_LEN; i++) begin
      if (pos == PosW'(i)) begin
        hdr_next[i] = rx_word.rx_byte;
      end
    end
    crc_next = crc_feed(crc, rx_word.rx_byte);
    pos_next = (pos < PosW'(MaxFrameBytes)) ? pos + PosW'(1) : pos;
  end

  assign snap.hdr         = hdr_next;
  assign snap.short_frame = (pos < PosW'(2));
  assign snap.crc         = crc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      crc <= CRC_INIT;
      hdr <= '0;
    end else if (accept) begin
      if (rx_word.last_byte) begin
        pos <= '0;
        crc <= CRC_INIT;
        hdr <= '0;
      end else begin
        pos <= pos_next;
        crc <= crc_next;
        hdr <= hdr_next;
      end
    end
  end

endmodule

### rtl/msrp_decode.sv
// Frame decode: status, sensor words and CRC residue check from a frame view.
// Depends on msrp_pkg.
module msrp_decode (
  input  msrp_pkg::frame_snap_t snap,
  input  logic [7:0]            slave_address,
  output msrp_pkg::res_word_t   res
);
  import msrp_pkg::*;

  always_comb begin
    res.temperature_raw = '0;
    res.humidity_raw    = '0;
    res.crc_ok          = (snap.crc == 16'h0000);
    if (snap.short_frame) begin
      res.frame_status = FS_SHORT;
    end else if (snap.hdr[0] != slave_address) begin
      res.frame_status = FS_OTHER_ADDR;
    end else if (snap.hdr[1] != FUNC_READ_HOLDING || snap.hdr[2] != READ_BYTE_COUNT) begin
      res.frame_status = FS_BAD_FUNC;
    end else begin
      res.frame_status    = FS_VALID;
      res.temperature_raw = {snap.hdr[3], snap.hdr[4]};
      res.humidity_raw    = {snap.hdr[5], snap.hdr[6]};
    end
  end

endmodule

### rtl/modbus_sensor_reply_parser.sv
// A result word is registered and presented in the cycle after its frame's last byte is taken.
// Throughput: one byte per cycle; the result register is the only stall point, and
//   rx_ready drops only while a result waits and res_ready is low.
// Reset (rst, synchronous, active high): CRC to 0xFFFF, position and header to zero,
//   slave_address to 1, result register empty. Depends on msrp_pkg, msrp_frame_acc,
//   msrp_decode.
module modbus_sensor_reply_parser #(
  parameter int MaxFrameBytes = msrp_pkg::MAX_FRAME_BYTES
) (
  input  logic                clk,
  input  logic                rst,
  // Received byte words
  input  logic                rx_valid,
  output logic                rx_ready,
  input  msrp_pkg::rx_word_t  rx_word,
  // Result words, one per frame
  output logic                res_valid,
  input  logic                res_ready,
  output msrp_pkg::res_word_t res_word,
  // Slave address register
  input  logic                cfg_write_en,
  input  logic [7:0]          cfg_write_data
);
  import msrp_pkg::*;

  logic        rx_accept;
  logic [7:0]  slave_address;
  frame_snap_t snap;
  res_word_t   res_calc;

  // A new byte can enter whenever the result register is free or draining.
  assign rx_ready  = !res_valid || res_ready;
  assign rx_accept = rx_valid && rx_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_ADDR_RESET;
    end else if (cfg_write_en) begin
      slave_address <= cfg_write_data;
    end
  end

  // Per-frame state; the snapshot already includes the byte on rx_word.
  msrp_frame_acc #(
    .MaxFrameBytes(MaxFrameBytes)
  ) u_frame_acc (
    .clk     (clk),
    .rst     (rst),
    .accept  (rx_accept),
    .rx_word (rx_word),
    .snap    (snap)
  );

  msrp_decode u_decode (
    .snap          (snap),
    .slave_address (slave_address),
    .res           (res_calc)
  );

  // Result register: loaded on the last byte of a frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (rx_accept && rx_word.last_byte) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_accept && rx_word.last_byte) begin
      res_word <= res_calc;
    end
  end

  // A mid-frame byte never produces a result.
  a_no_mid_result: assert property (@(posedge clk) disable iff (rst)
    (rx_accept && !rx_word.last_byte && !res_valid) |=> !res_valid)
    else $error("result appeared for a mid-frame byte");

  // The last byte of a frame always produces a result.
  a_last_gives_result: assert property (@(posedge clk) disable iff (rst)
    (rx_accept && rx_word.last_byte) |=> res_valid)
    else $error("frame end produced no result");

  // Sensor words are zero for any reply that is not a valid read.
  a_words_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_word.frame_status != FS_VALID) |->
      (res_word.temperature_raw == 16'h0000 && res_word.humidity_raw == 16'h0000))
    else $error("nonzero sensor word on a rejected reply");

  // Input only stalls behind a waiting result.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> (res_valid && !res_ready))
    else $error("input stalled with result register free");

endmodule
